// File: sv/ttlc_pkg.sv
// ----------------------------------------------------------------------------
// ttlc_pkg
// Shared types, codes and constants of the tape transport loop controller.
// ----------------------------------------------------------------------------
package ttlc_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int SAMPLE_W          = 29;
	localparam int CUE_W             = 13;
	localparam int OP_W              = 4;
	localparam int FACTOR_W          = 22;
	localparam int WHEEL_W           = 22;
	localparam int FRAC_OUT_W        = 16;
	localparam int SPEED_W           = 28;
	localparam int CFG_IDX_W         = 3;

	localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
	localparam logic [OP_W-1:0] OP_PLAY_FWD   = 4'd1;
	localparam logic [OP_W-1:0] OP_PLAY_BWD   = 4'd2;
	localparam logic [OP_W-1:0] OP_CUE_FWD    = 4'd3;
	localparam logic [OP_W-1:0] OP_CUE_BWD    = 4'd4;
	localparam logic [OP_W-1:0] OP_STOP       = 4'd5;
	localparam logic [OP_W-1:0] OP_PAUSE      = 4'd6;
	localparam logic [OP_W-1:0] OP_JUMP_BEGIN = 4'd7;
	localparam logic [OP_W-1:0] OP_JUMP_END   = 4'd8;
	localparam logic [OP_W-1:0] OP_JUMP_NEXT  = 4'd9;
	localparam logic [OP_W-1:0] OP_JUMP_PREV  = 4'd10;

	localparam logic [1:0] STATUS_BEGIN  = 2'd0;
	localparam logic [1:0] STATUS_MIDDLE = 2'd1;
	localparam logic [1:0] STATUS_END    = 2'd2;

	localparam logic [1:0] XPORT_IDLE = 2'd0;
	localparam logic [1:0] XPORT_FWD  = 2'd1;
	localparam logic [1:0] XPORT_BWD  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TAPE_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CUE_SPEED   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_BOUNCE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_START  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_END    = 3'd4;

	// 44100 * 60 samples
	localparam logic [SAMPLE_W-1:0] TAPE_LENGTH_RST = 29'd2646000;
	localparam logic [CUE_W-1:0]    CUE_SPEED_RST   = 13'd768;

	typedef struct packed {
		logic [SAMPLE_W-1:0] tape_length;
		logic [CUE_W-1:0]    cue_speed;
		logic                loop_bounce;
		logic [SAMPLE_W-1:0] loop_start_pos;
		logic [SAMPLE_W-1:0] loop_end_pos;
	} ttlc_cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]            operation;
		logic [FACTOR_W-1:0]        speed_factor;
		logic signed [WHEEL_W-1:0]  wheel_speed;
	} ttlc_tick_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0]       head_index;
		logic [FRAC_OUT_W-1:0]     head_fraction;
		logic [1:0]                tape_status;
		logic [1:0]                transport_state;
		logic                      cueing;
		logic signed [SPEED_W-1:0] head_speed;
	} ttlc_result_t;

	typedef struct packed {
		logic play_fwd;
		logic play_bwd;
		logic cue_fwd;
		logic cue_bwd;
		logic pause;
	} ttlc_flags_t;

endpackage

// File: sv/ttlc_if.sv
// ----------------------------------------------------------------------------
// ttlc_if
// Channel interfaces: tick input, result output and register write port.
// ----------------------------------------------------------------------------
interface ttlc_tick_if
	import ttlc_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           operation;
	logic [FACTOR_W-1:0]       speed_factor;
	logic signed [WHEEL_W-1:0] wheel_speed;

	modport source (output valid, operation, speed_factor, wheel_speed, input ready);
	modport sink   (input valid, operation, speed_factor, wheel_speed, output ready);
endinterface

interface ttlc_result_if
	import ttlc_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic [SAMPLE_W-1:0]       head_index;
	logic [FRAC_OUT_W-1:0]     head_fraction;
	logic [1:0]                tape_status;
	logic [1:0]                transport_state;
	logic                      cueing;
	logic signed [SPEED_W-1:0] head_speed;

	modport source (output valid, head_index, head_fraction, tape_status,
		transport_state, cueing, head_speed, input ready);
	modport sink   (input valid, head_index, head_fraction, tape_status,
		transport_state, cueing, head_speed, output ready);
endinterface

interface ttlc_cfg_if
	import ttlc_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SAMPLE_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/tape_transport_loop_controller_core.sv
// ----------------------------------------------------------------------------
// tape_transport_loop_controller_core
// Moves a fixed-point tape head once per sample tick under transport control.
//
// Channels: tick (sink) carries operation, speed_factor and wheel_speed for one
// sample; result (source) returns head position, tape status, transport state,
// cue flag and the applied head speed, one result per tick. cfg writes one
// register per transaction and is always ready; write it only while idle.
// A tick is registered on acceptance; its result is registered from that tick
// register when the result channel can take it, and is then valid.
// Throughput: one tick per cycle unless result is held. Head position and
// transport flags update in the same cycle the result is registered, via one
// pass of the step logic (cue multiply, head add, loop and end compares).
// Reset: head at 0, all play, cue and pause flags clear, registers at defaults.
// Stall: while result is held, the tick register keeps its item and tick.ready
// drops once that register is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module tape_transport_loop_controller_core
	import ttlc_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ttlc_cfg_if.sink      cfg,
	ttlc_tick_if.sink     tick,
	ttlc_result_if.source result
);

	localparam int PW = SAMPLE_W + FRACTION_BITS;

	ttlc_cfg_t    regs;
	ttlc_tick_t   tick_s1;
	logic         valid_s1;
	logic [PW-1:0] pos_q, pos_next;
	ttlc_flags_t  flags_q, flags_next;
	ttlc_result_t res_next, res_q;
	logic         res_valid_q;
	logic         advance;

	ttlc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ttlc_step #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_step (
		.regs       (regs),
		.tick       (tick_s1),
		.pos        (pos_q),
		.flags      (flags_q),
		.pos_next   (pos_next),
		.flags_next (flags_next),
		.result     (res_next)
	);

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1.operation    <= tick.operation;
			tick_s1.speed_factor <= tick.speed_factor;
			tick_s1.wheel_speed  <= tick.wheel_speed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			flags_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pos_q   <= pos_next;
				flags_q <= flags_next;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.head_index      = res_q.head_index;
	assign result.head_fraction   = res_q.head_fraction;
	assign result.tape_status     = res_q.tape_status;
	assign result.transport_state = res_q.transport_state;
	assign result.cueing          = res_q.cueing;
	assign result.head_speed      = res_q.head_speed;

`ifndef SYNTHESIS
	a_play_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(flags_q.play_fwd && flags_q.play_bwd))
		else $error("play forward and backward both set");

	a_cue_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(flags_q.cue_fwd && flags_q.cue_bwd))
		else $error("cue forward and backward both set");

	a_begin_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.tape_status == STATUS_BEGIN
		|-> result.head_index == '0 && result.head_fraction == '0)
		else $error("begin status with head away from zero");

	a_advance_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result.valid)
		else $error("processed tick produced no result");

	a_head_stored: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> pos_q[PW-1:FRACTION_BITS] == result.head_index)
		else $error("stored head differs from reported head");
`endif

endmodule

// File: sv/ttlc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ttlc_cfg_regs
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module ttlc_cfg_regs
	import ttlc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ttlc_cfg_if.sink   cfg,
	output ttlc_cfg_t  regs
);

	ttlc_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.tape_length    <= TAPE_LENGTH_RST;
			regs_q.cue_speed      <= CUE_SPEED_RST;
			regs_q.loop_bounce    <= 1'b1;
			regs_q.loop_start_pos <= '0;
			regs_q.loop_end_pos   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TAPE_LENGTH: regs_q.tape_length    <= cfg.data;
				REG_CUE_SPEED:   regs_q.cue_speed      <= cfg.data[CUE_W-1:0];
				REG_LOOP_BOUNCE: regs_q.loop_bounce    <= cfg.data[0];
				REG_LOOP_START:  regs_q.loop_start_pos <= cfg.data;
				REG_LOOP_END:    regs_q.loop_end_pos   <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// File: sv/ttlc_step.sv
// ----------------------------------------------------------------------------
// ttlc_step
// Single-tick update: command decode, speed, head move, loop and clamp.
// ----------------------------------------------------------------------------
module ttlc_step
	import ttlc_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  ttlc_cfg_t                          regs,
	input  ttlc_tick_t                         tick,
	input  logic [SAMPLE_W+FRACTION_BITS-1:0]  pos,
	input  ttlc_flags_t                        flags,
	output logic [SAMPLE_W+FRACTION_BITS-1:0]  pos_next,
	output ttlc_flags_t                        flags_next,
	output ttlc_result_t                       result
);

	localparam int PW = SAMPLE_W + FRACTION_BITS;
	localparam int SW = PW + 2;
	localparam int UP = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
	localparam int DN = (FRACTION_BITS >= 16) ? 0 : 16 - FRACTION_BITS;
	localparam int FW = FRACTION_BITS + 16;

	logic [SAMPLE_W-1:0]          len_s;
	logic [PW-1:0]                len_fx, s_fx, e_fx, lo_fx, hi_fx, end_fx, p_jmp;
	logic [1:0]                   status0;
	logic [1:0]                   status;
	ttlc_flags_t                  fc;
	logic                         play, play_fwd, cue, cue_fwd;
	logic [FACTOR_W+CUE_W-1:0]    prod;
	logic signed [SPEED_W-1:0]    speed;
	logic [SPEED_W-1:0]           mag;
	logic [SW-1:0]                step_mag;
	logic signed [SW-1:0]         step, p_sum, p_loop, lo_sw, hi_sw, len_sw;
	logic                         hit;
	logic [FW-1:0]                frac_w;

	assign len_s  = (regs.tape_length == '0) ? SAMPLE_W'(1) : regs.tape_length;
	assign len_fx = {len_s, {FRACTION_BITS{1'b0}}};
	assign end_fx = {len_s - SAMPLE_W'(1), {FRACTION_BITS{1'b0}}};
	assign s_fx   = {regs.loop_start_pos, {FRACTION_BITS{1'b0}}};
	assign e_fx   = {regs.loop_end_pos, {FRACTION_BITS{1'b0}}};
	assign lo_fx  = (s_fx < e_fx) ? s_fx : e_fx;
	assign hi_fx  = (s_fx < e_fx) ? e_fx : s_fx;
	assign lo_sw  = signed'({2'b00, lo_fx});
	assign hi_sw  = signed'({2'b00, hi_fx});
	assign len_sw = signed'({2'b00, len_fx});

	always_comb begin
		fc    = flags;
		p_jmp = pos;
		unique case (tick.operation)
			OP_PLAY_FWD: begin
				fc.play_fwd = 1'b1;
				fc.play_bwd = 1'b0;
			end
			OP_PLAY_BWD: begin
				fc.play_bwd = 1'b1;
				fc.play_fwd = 1'b0;
			end
			OP_CUE_FWD: begin
				fc.cue_fwd = 1'b1;
				fc.cue_bwd = 1'b0;
			end
			OP_CUE_BWD: begin
				fc.cue_bwd = 1'b1;
				fc.cue_fwd = 1'b0;
			end
			OP_STOP: begin
				fc.play_fwd = 1'b0;
				fc.play_bwd = 1'b0;
				fc.cue_fwd  = 1'b0;
				fc.cue_bwd  = 1'b0;
			end
			OP_PAUSE:      fc.pause = !flags.pause;
			OP_JUMP_BEGIN: p_jmp = '0;
			OP_JUMP_END:   p_jmp = len_fx;
			OP_JUMP_NEXT: begin
				priority if (pos < lo_fx) p_jmp = lo_fx;
				else if (pos < hi_fx)     p_jmp = hi_fx;
				else                      p_jmp = len_fx;
			end
			OP_JUMP_PREV: begin
				priority if (pos > hi_fx) p_jmp = hi_fx;
				else if (pos > lo_fx)     p_jmp = lo_fx;
				else                      p_jmp = '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		priority if (p_jmp == '0) status0 = STATUS_BEGIN;
		else if (p_jmp >= len_fx) status0 = STATUS_END;
		else                      status0 = STATUS_MIDDLE;
	end

	assign play_fwd = !fc.play_bwd;
	assign cue_fwd  = !fc.cue_bwd;

	always_comb begin
		play = fc.play_fwd || fc.play_bwd;
		cue  = fc.cue_fwd || fc.cue_bwd;
		if (status0 == STATUS_BEGIN) begin
			if (!cue_fwd)  cue  = 1'b0;
			if (!play_fwd) play = 1'b0;
		end else if (status0 == STATUS_END) begin
			if (cue_fwd)  cue  = 1'b0;
			if (play_fwd) play = 1'b0;
		end
	end

	assign prod = (FACTOR_W+CUE_W)'(tick.speed_factor) * (FACTOR_W+CUE_W)'(regs.cue_speed);

	always_comb begin
		priority if ((!play && !cue) || (play && fc.pause && !cue)) begin
			speed = SPEED_W'(tick.wheel_speed);
		end else if (cue) begin
			speed = signed'({1'b0, prod[FACTOR_W+CUE_W-1:8]});
			if (!cue_fwd) speed = -speed;
		end else begin
			speed = signed'(SPEED_W'(tick.speed_factor));
			if (!play_fwd) speed = -speed;
		end
	end

	// rescale by magnitude so that a shift down truncates toward zero
	assign mag      = speed[SPEED_W-1] ? SPEED_W'(-speed) : SPEED_W'(speed);
	assign step_mag = (SW'(mag) << UP) >> DN;
	assign step     = speed[SPEED_W-1] ? -signed'(step_mag) : signed'(step_mag);
	assign p_sum    = signed'({2'b00, p_jmp}) + step;
	assign hit      = (!play_fwd && p_sum <= lo_sw) || (play_fwd && p_sum > hi_sw);

	always_comb begin
		flags_next = fc;
		p_loop     = p_sum;
		if (s_fx != e_fx && play && hit) begin
			if (regs.loop_bounce) begin
				flags_next.play_fwd = !fc.play_fwd;
				flags_next.play_bwd = !fc.play_bwd;
			end else begin
				p_loop = play_fwd ? lo_sw : hi_sw;
			end
		end
		priority if (p_loop[SW-1] || p_loop == '0) begin
			flags_next.play_bwd = 1'b0;
			flags_next.cue_bwd  = 1'b0;
			pos_next            = '0;
			status              = STATUS_BEGIN;
		end else if (p_loop >= len_sw) begin
			flags_next.play_fwd = 1'b0;
			flags_next.cue_fwd  = 1'b0;
			pos_next            = end_fx;
			status              = STATUS_END;
		end else begin
			pos_next            = p_loop[PW-1:0];
			status              = STATUS_MIDDLE;
		end
	end

	assign frac_w = (FW'(pos_next[FRACTION_BITS-1:0]) << DN) >> UP;

	assign result.head_index      = pos_next[PW-1:FRACTION_BITS];
	assign result.head_fraction   = frac_w[FRAC_OUT_W-1:0];
	assign result.tape_status     = status;
	assign result.transport_state = !play ? XPORT_IDLE : (play_fwd ? XPORT_FWD : XPORT_BWD);
	assign result.cueing          = cue;
	assign result.head_speed      = speed;

endmodule
